// ----- src/rvdec_pkg.sv -----
// rvdec_pkg: shared types and codes for the RV32IM decode stage.
// Used by every module of the decoder and by its checker.
`default_nettype none
package rvdec_pkg;

  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  typedef enum logic [2:0] {
    FMT_R    = 3'd0,
    FMT_I    = 3'd1,
    FMT_S    = 3'd2,
    FMT_B    = 3'd3,
    FMT_U    = 3'd4,
    FMT_J    = 3'd5,
    FMT_NONE = 3'd6
  } fmt_t;

  typedef enum logic [5:0] {
    NAME_UNKNOWN = 6'd0,
    NAME_LUI, NAME_AUIPC, NAME_JAL, NAME_JALR,
    NAME_BEQ, NAME_BNE, NAME_BLT, NAME_BGE, NAME_BLTU, NAME_BGEU,
    NAME_LB, NAME_LH, NAME_LW, NAME_LBU, NAME_LHU,
    NAME_SB, NAME_SH, NAME_SW,
    NAME_ADDI, NAME_SLTI, NAME_SLTIU, NAME_XORI, NAME_ORI, NAME_ANDI,
    NAME_SLLI, NAME_SRLI, NAME_SRAI,
    NAME_ADD, NAME_SUB, NAME_SLL, NAME_SLT, NAME_SLTU, NAME_XOR, NAME_SRL,
    NAME_SRA, NAME_OR, NAME_AND,
    NAME_MUL, NAME_MULH, NAME_MULHSU, NAME_MULHU, NAME_DIV, NAME_DIVU,
    NAME_REM, NAME_REMU,
    NAME_FENCE, NAME_ECALL, NAME_EBREAK
  } name_t;

  typedef struct packed {
    logic [31:0] instr_word;
    logic [31:0] pc_in;
  } instr_t;

  typedef struct packed {
    logic [31:0] next_pc;
    logic        stop;
    logic [5:0]  name_code;
    logic [2:0]  format;
    logic [19:0] packed_imm;
    logic [4:0]  dest_reg;
    logic [4:0]  src1_reg;
    logic [4:0]  src2_reg;
    logic        uses_src1;
    logic        uses_src2;
    logic        writes_dest;
  } decoded_t;

  // classified beat handed from front to back
  typedef struct packed {
    logic [31:0] word;
    logic [31:0] pc;
    name_t       name;
    fmt_t        fmt;
    logic        jal;
    logic        ret;
  } entry_t;

endpackage
`default_nettype wire

// ----- src/rvdec_front.sv -----
// rvdec_front: accepts instruction beats, keeps the phase bit and classifies
// active-phase beats into name and format. Depends on rvdec_pkg.
`default_nettype none
module rvdec_front (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              instr_valid,
  output logic                   instr_ready,
  input  wire rvdec_pkg::instr_t instr,
  input  wire logic              q_full,
  output logic                   q_push,
  output rvdec_pkg::entry_t      q_entry
);

  localparam logic [4:0] OP_LOAD   = 5'h00;
  localparam logic [4:0] OP_FENCE  = 5'h03;
  localparam logic [4:0] OP_ALUI   = 5'h04;
  localparam logic [4:0] OP_AUIPC  = 5'h05;
  localparam logic [4:0] OP_STORE  = 5'h08;
  localparam logic [4:0] OP_ALU    = 5'h0C;
  localparam logic [4:0] OP_LUI    = 5'h0D;
  localparam logic [4:0] OP_BRANCH = 5'h18;
  localparam logic [4:0] OP_JALR   = 5'h19;
  localparam logic [4:0] OP_JAL    = 5'h1B;
  localparam logic [4:0] OP_SYSTEM = 5'h1C;
  localparam logic [6:0] F7_ZERO   = 7'b0000000;
  localparam logic [6:0] F7_ALT    = 7'b0100000;
  localparam logic [6:0] F7_MUL    = 7'b0000001;
  localparam logic [24:0] SYS_EBREAK_BITS = 25'b0000000000010000000000000;

  logic phase;
  logic accept;
  logic [31:0] w;
  logic [2:0]  f3;
  logic [6:0]  f7;
  rvdec_pkg::name_t name;
  rvdec_pkg::fmt_t  fmt;
  logic jal;
  logic ret;

  assign instr_ready = !q_full;
  assign accept      = instr_valid && instr_ready;
  assign q_push      = accept && phase;
  assign w  = instr.instr_word;
  assign f3 = w[14:12];
  assign f7 = w[31:25];

  always_comb begin
    name = rvdec_pkg::NAME_UNKNOWN;
    fmt  = rvdec_pkg::FMT_NONE;
    jal  = 1'b0;
    ret  = 1'b0;
    if (w[1:0] == 2'b11) begin
      case (w[6:2])
        OP_LOAD: begin
          fmt = rvdec_pkg::FMT_I;
          case (f3)
            3'd0: name = rvdec_pkg::NAME_LB;
            3'd1: name = rvdec_pkg::NAME_LH;
            3'd2: name = rvdec_pkg::NAME_LW;
            3'd4: name = rvdec_pkg::NAME_LBU;
            3'd5: name = rvdec_pkg::NAME_LHU;
            default: name = rvdec_pkg::NAME_UNKNOWN;
          endcase
        end
        OP_FENCE: begin
          fmt = rvdec_pkg::FMT_I;
          if (f3 == 3'd0) name = rvdec_pkg::NAME_FENCE;
        end
        OP_ALUI: begin
          fmt = rvdec_pkg::FMT_I;
          case (f3)
            3'd0: name = rvdec_pkg::NAME_ADDI;
            3'd1: name = (f7 == F7_ZERO) ? rvdec_pkg::NAME_SLLI : rvdec_pkg::NAME_UNKNOWN;
            3'd2: name = rvdec_pkg::NAME_SLTI;
            3'd3: name = rvdec_pkg::NAME_SLTIU;
            3'd4: name = rvdec_pkg::NAME_XORI;
            3'd5: begin
              if (f7 == F7_ZERO) name = rvdec_pkg::NAME_SRLI;
              else if (f7 == F7_ALT) name = rvdec_pkg::NAME_SRAI;
            end
            3'd6: name = rvdec_pkg::NAME_ORI;
            default: name = rvdec_pkg::NAME_ANDI;
          endcase
        end
        OP_AUIPC: begin
          fmt  = rvdec_pkg::FMT_U;
          name = rvdec_pkg::NAME_AUIPC;
        end
        OP_STORE: begin
          fmt = rvdec_pkg::FMT_S;
          case (f3)
            3'd0: name = rvdec_pkg::NAME_SB;
            3'd1: name = rvdec_pkg::NAME_SH;
            3'd2: name = rvdec_pkg::NAME_SW;
            default: name = rvdec_pkg::NAME_UNKNOWN;
          endcase
        end
        OP_ALU: begin
          fmt = rvdec_pkg::FMT_R;
          if (f7 == F7_ZERO) begin
            case (f3)
              3'd0: name = rvdec_pkg::NAME_ADD;
              3'd1: name = rvdec_pkg::NAME_SLL;
              3'd2: name = rvdec_pkg::NAME_SLT;
              3'd3: name = rvdec_pkg::NAME_SLTU;
              3'd4: name = rvdec_pkg::NAME_XOR;
              3'd5: name = rvdec_pkg::NAME_SRL;
              3'd6: name = rvdec_pkg::NAME_OR;
              default: name = rvdec_pkg::NAME_AND;
            endcase
          end else if (f7 == F7_MUL) begin
            case (f3)
              3'd0: name = rvdec_pkg::NAME_MUL;
              3'd1: name = rvdec_pkg::NAME_MULH;
              3'd2: name = rvdec_pkg::NAME_MULHSU;
              3'd3: name = rvdec_pkg::NAME_MULHU;
              3'd4: name = rvdec_pkg::NAME_DIV;
              3'd5: name = rvdec_pkg::NAME_DIVU;
              3'd6: name = rvdec_pkg::NAME_REM;
              default: name = rvdec_pkg::NAME_REMU;
            endcase
          end else if (f7 == F7_ALT && f3 == 3'd0) begin
            name = rvdec_pkg::NAME_SUB;
          end else if (f7 == F7_ALT && f3 == 3'd5) begin
            name = rvdec_pkg::NAME_SRA;
          end
        end
        OP_LUI: begin
          fmt  = rvdec_pkg::FMT_U;
          name = rvdec_pkg::NAME_LUI;
        end
        OP_BRANCH: begin
          fmt = rvdec_pkg::FMT_B;
          case (f3)
            3'd0: name = rvdec_pkg::NAME_BEQ;
            3'd1: name = rvdec_pkg::NAME_BNE;
            3'd4: name = rvdec_pkg::NAME_BLT;
            3'd5: name = rvdec_pkg::NAME_BGE;
            3'd6: name = rvdec_pkg::NAME_BLTU;
            3'd7: name = rvdec_pkg::NAME_BGEU;
            default: name = rvdec_pkg::NAME_UNKNOWN;
          endcase
        end
        OP_JALR: begin
          fmt = rvdec_pkg::FMT_I;
          if (f3 == 3'd0) begin
            name = rvdec_pkg::NAME_JALR;
            ret  = (w[31:20] == 12'd0) && (w[11:7] == 5'd0) && (w[19:15] == 5'd1);
          end
        end
        OP_JAL: begin
          fmt  = rvdec_pkg::FMT_J;
          name = rvdec_pkg::NAME_JAL;
          jal  = 1'b1;
        end
        OP_SYSTEM: begin
          fmt = rvdec_pkg::FMT_I;
          if (w[31:7] == 25'd0) name = rvdec_pkg::NAME_ECALL;
          else if (w[31:7] == SYS_EBREAK_BITS) name = rvdec_pkg::NAME_EBREAK;
        end
        default: begin
          fmt = rvdec_pkg::FMT_NONE;
        end
      endcase
    end
  end

  always_comb begin
    q_entry.word = w;
    q_entry.pc   = instr.pc_in;
    q_entry.name = name;
    q_entry.fmt  = fmt;
    q_entry.jal  = jal;
    q_entry.ret  = ret;
  end

  // phase flips on every accepted beat; only active beats are queued
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= 1'b0;
    end else if (accept) begin
      phase <= !phase;
    end
  end

endmodule
`default_nettype wire

// ----- src/rvdec_queue.sv -----
// rvdec_queue: small FIFO of classified beats between front and back.
// Depends on rvdec_pkg.
`default_nettype none
module rvdec_queue (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire rvdec_pkg::entry_t push_entry,
  output logic                   full,
  output logic                   not_empty,
  input  wire logic              pop,
  output rvdec_pkg::entry_t      head
);

  rvdec_pkg::entry_t slots [rvdec_pkg::QUEUE_DEPTH];
  logic [rvdec_pkg::QUEUE_AW-1:0] wr_ptr;
  logic [rvdec_pkg::QUEUE_AW-1:0] rd_ptr;
  logic [rvdec_pkg::QUEUE_AW:0]   count;
  logic do_push;
  logic do_pop;

  assign full      = (count == (rvdec_pkg::QUEUE_AW+1)'(rvdec_pkg::QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign head      = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == rvdec_pkg::QUEUE_AW'(rvdec_pkg::QUEUE_DEPTH - 1)) ?
                  '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == rvdec_pkg::QUEUE_AW'(rvdec_pkg::QUEUE_DEPTH - 1)) ?
                  '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// ----- src/rvdec_back.sv -----
// rvdec_back: builds the packed immediate, next PC and use flags from a
// classified beat and holds the result in the output register. Depends on rvdec_pkg.
`default_nettype none
module rvdec_back (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              q_not_empty,
  input  wire rvdec_pkg::entry_t q_head,
  output logic                   q_pop,
  output logic                   dec_valid,
  input  wire logic              dec_ready,
  output rvdec_pkg::decoded_t    dec
);

  logic [31:0] w;
  logic [19:0] imm;
  logic [31:0] offset;
  logic u1;
  logic u2;
  logic wd;
  rvdec_pkg::decoded_t result;
  rvdec_pkg::fmt_t fmt;

  assign w     = q_head.word;
  assign fmt   = q_head.fmt;
  assign q_pop = q_not_empty && (!dec_valid || dec_ready);

  always_comb begin
    case (fmt)
      rvdec_pkg::FMT_I: imm = {8'd0, w[31:20]};
      rvdec_pkg::FMT_S: imm = {8'd0, w[31:25], w[11:7]};
      rvdec_pkg::FMT_B: imm = {8'd0, w[31], w[7], w[30:25], w[11:8]};
      rvdec_pkg::FMT_U: imm = w[31:12];
      rvdec_pkg::FMT_J: imm = {w[31], w[19:12], w[20], w[30:21]};
      default:          imm = 20'd0;
    endcase
  end

  // JAL byte offset imm[20:2] as a word offset
  assign offset = {{13{imm[19]}}, imm[19:1]};

  assign u1 = (fmt == rvdec_pkg::FMT_R) || (fmt == rvdec_pkg::FMT_I) ||
              (fmt == rvdec_pkg::FMT_S) || (fmt == rvdec_pkg::FMT_B);
  assign u2 = (fmt == rvdec_pkg::FMT_R) || (fmt == rvdec_pkg::FMT_S) ||
              (fmt == rvdec_pkg::FMT_B);
  assign wd = u1 && (fmt != rvdec_pkg::FMT_S) || (fmt == rvdec_pkg::FMT_U) ||
              (fmt == rvdec_pkg::FMT_J);

  always_comb begin
    result.next_pc     = q_head.jal ? (q_head.pc + offset) : (q_head.pc + 32'd1);
    result.stop        = q_head.ret;
    result.name_code   = q_head.name;
    result.format      = fmt;
    result.packed_imm  = imm;
    result.dest_reg    = w[11:7];
    result.src1_reg    = w[19:15];
    result.src2_reg    = w[24:20];
    result.uses_src1   = u1;
    result.uses_src2   = u2;
    result.writes_dest = wd;
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      dec <= result;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dec_valid <= 1'b0;
    end else if (q_pop) begin
      dec_valid <= 1'b1;
    end else if (dec_ready) begin
      dec_valid <= 1'b0;
    end
  end

endmodule
`default_nettype wire

// ----- src/rv32im_instruction_decoder_top.sv -----
// An active-phase beat is written into a queue slot, then registered on dec by the output register.
// Throughput: one instruction accepted per cycle while the queue is not full; every second one yields a beat.
// A two-entry queue between classifier and output register sets the stall decoupling.
// Reset (synchronous, rst high) clears the phase bit, the queue and the output valid.
// Depends on rvdec_pkg, rvdec_front, rvdec_queue, rvdec_back.
`default_nettype none
module rv32im_instruction_decoder_top (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              instr_valid,
  output logic                   instr_ready,
  input  wire rvdec_pkg::instr_t instr,
  output logic                   dec_valid,
  input  wire logic              dec_ready,
  output rvdec_pkg::decoded_t    dec
);

  logic q_full;
  logic q_push;
  logic q_not_empty;
  logic q_pop;
  rvdec_pkg::entry_t q_in;
  rvdec_pkg::entry_t q_head;

  rvdec_front u_front (
    .clk         (clk),
    .rst         (rst),
    .instr_valid (instr_valid),
    .instr_ready (instr_ready),
    .instr       (instr),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_entry     (q_in)
  );

  rvdec_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (q_in),
    .full       (q_full),
    .not_empty  (q_not_empty),
    .pop        (q_pop),
    .head       (q_head)
  );

  rvdec_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_not_empty (q_not_empty),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .dec_valid   (dec_valid),
    .dec_ready   (dec_ready),
    .dec         (dec)
  );

endmodule
`default_nettype wire

// ----- src/rvdec_checker.sv -----
// rvdec_checker: port-level assertions for the decoder, bound to the top level.
// Depends on rvdec_pkg.
`default_nettype none
module rvdec_checker (
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                instr_valid,
  input wire logic                instr_ready,
  input wire rvdec_pkg::instr_t   instr,
  input wire logic                dec_valid,
  input wire logic                dec_ready,
  input wire rvdec_pkg::decoded_t dec
);

  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    instr_valid && !instr_ready |=> instr_valid && $stable(instr))
    else $error("instruction beat dropped or changed while stalled");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    dec_valid && !dec_ready |=> dec_valid && $stable(dec))
    else $error("result beat dropped or changed while stalled");

  a_stop_jalr: assert property (@(posedge clk) disable iff (rst)
    dec_valid && dec.stop |-> dec.name_code == rvdec_pkg::NAME_JALR &&
      dec.dest_reg == 5'd0 && dec.src1_reg == 5'd1 && dec.packed_imm == 20'd0)
    else $error("stop set on a beat that is not ret");

  a_no_imm: assert property (@(posedge clk) disable iff (rst)
    dec_valid && (dec.format == rvdec_pkg::FMT_R || dec.format == rvdec_pkg::FMT_NONE)
      |-> dec.packed_imm == 20'd0)
    else $error("immediate present for R or unknown format");

  a_flags: assert property (@(posedge clk) disable iff (rst)
    dec_valid |-> (!dec.uses_src2 || dec.uses_src1) &&
      (dec.format != rvdec_pkg::FMT_NONE ||
       (!dec.uses_src1 && !dec.writes_dest && dec.name_code == rvdec_pkg::NAME_UNKNOWN)))
    else $error("register use flags inconsistent with format");

endmodule

bind rv32im_instruction_decoder_top rvdec_checker u_rvdec_checker (.*);
`default_nettype wire

// ----- bench/rvdec_tb_pkg.sv -----
// rvdec_tb_pkg: encoding constants, an instruction word builder and the
// decode scoreboard used by the RV32IM decode stage bench.
// Depends on rvdec_pkg for the beat types and the name and format codes.
package rvdec_tb_pkg;
  import rvdec_pkg::*;

  localparam logic [1:0] QUAD = 2'b11;

  localparam logic [4:0] OP_LOAD     = 5'h00;
  localparam logic [4:0] OP_MISC_MEM = 5'h03;
  localparam logic [4:0] OP_IMM      = 5'h04;
  localparam logic [4:0] OP_AUIPC    = 5'h05;
  localparam logic [4:0] OP_STORE    = 5'h08;
  localparam logic [4:0] OP_REG      = 5'h0C;
  localparam logic [4:0] OP_LUI      = 5'h0D;
  localparam logic [4:0] OP_BRANCH   = 5'h18;
  localparam logic [4:0] OP_JALR     = 5'h19;
  localparam logic [4:0] OP_JAL      = 5'h1B;
  localparam logic [4:0] OP_SYSTEM   = 5'h1C;

  localparam logic [2:0] F3_ZERO = 3'd0;
  localparam logic [2:0] F3_SLL  = 3'd1;
  localparam logic [2:0] F3_SR   = 3'd5;

  localparam logic [6:0] F7_ZERO = 7'h00;
  localparam logic [6:0] F7_MUL  = 7'h01;
  localparam logic [6:0] F7_ALT  = 7'h20;

  localparam logic [24:0] SYS_ECALL_BITS  = 25'h0000000;
  localparam logic [24:0] SYS_EBREAK_BITS = 25'h0002000;

  localparam logic [4:0] ZERO_REG = 5'd0;
  localparam logic [4:0] RA_REG   = 5'd1;

  function automatic logic [31:0] make_word(logic [6:0] f7, logic [4:0] rs2,
                                            logic [4:0] rs1, logic [2:0] f3,
                                            logic [4:0] rd, logic [4:0] op);
    return {f7, rs2, rs1, f3, rd, op, QUAD};
  endfunction

  function automatic int unsigned draw_gap(bit calm);
    if (calm || $urandom_range(0, 1) == 0) return 0;
    return $urandom_range(0, 18);
  endfunction

  class decode_scoreboard;
    decoded_t pending_decodes[$];
    bit decode_phase;
    int errors;

    name_t load_names [8] = '{NAME_LB, NAME_LH, NAME_LW, NAME_UNKNOWN,
                              NAME_LBU, NAME_LHU, NAME_UNKNOWN, NAME_UNKNOWN};
    name_t store_names [8] = '{NAME_SB, NAME_SH, NAME_SW, NAME_UNKNOWN,
                               NAME_UNKNOWN, NAME_UNKNOWN, NAME_UNKNOWN, NAME_UNKNOWN};
    name_t branch_names [8] = '{NAME_BEQ, NAME_BNE, NAME_UNKNOWN, NAME_UNKNOWN,
                                NAME_BLT, NAME_BGE, NAME_BLTU, NAME_BGEU};
    name_t alui_names [8] = '{NAME_ADDI, NAME_SLLI, NAME_SLTI, NAME_SLTIU,
                              NAME_XORI, NAME_SRLI, NAME_ORI, NAME_ANDI};
    name_t alu_names [8] = '{NAME_ADD, NAME_SLL, NAME_SLT, NAME_SLTU,
                             NAME_XOR, NAME_SRL, NAME_OR, NAME_AND};
    name_t mul_names [8] = '{NAME_MUL, NAME_MULH, NAME_MULHSU, NAME_MULHU,
                             NAME_DIV, NAME_DIVU, NAME_REM, NAME_REMU};

    function new();
      decode_phase = 1'b0;
      errors = 0;
    endfunction

    function int pending();
      return pending_decodes.size();
    endfunction

    function decoded_t decode_instr(logic [31:0] w, logic [31:0] pc);
      decoded_t d;
      fmt_t fmt;
      name_t name;
      logic [6:0] f7;
      logic [2:0] f3;
      logic [19:0] imm;
      logic jal;
      logic ret;
      f7 = w[31:25];
      f3 = w[14:12];
      fmt = FMT_NONE;
      name = NAME_UNKNOWN;
      jal = 1'b0;
      ret = 1'b0;
      if (w[1:0] == QUAD) begin
        case (w[6:2])
          OP_LOAD: begin
            fmt = FMT_I;
            name = load_names[f3];
          end
          OP_MISC_MEM: begin
            fmt = FMT_I;
            if (f3 == F3_ZERO) name = NAME_FENCE;
          end
          OP_IMM: begin
            fmt = FMT_I;
            if (f3 == F3_SLL) begin
              if (f7 == F7_ZERO) name = NAME_SLLI;
            end else if (f3 == F3_SR) begin
              if (f7 == F7_ZERO) name = NAME_SRLI;
              else if (f7 == F7_ALT) name = NAME_SRAI;
            end else begin
              name = alui_names[f3];
            end
          end
          OP_AUIPC: begin
            fmt = FMT_U;
            name = NAME_AUIPC;
          end
          OP_STORE: begin
            fmt = FMT_S;
            name = store_names[f3];
          end
          OP_REG: begin
            fmt = FMT_R;
            if (f7 == F7_ZERO) name = alu_names[f3];
            else if (f7 == F7_MUL) name = mul_names[f3];
            else if (f7 == F7_ALT && f3 == F3_ZERO) name = NAME_SUB;
            else if (f7 == F7_ALT && f3 == F3_SR) name = NAME_SRA;
          end
          OP_LUI: begin
            fmt = FMT_U;
            name = NAME_LUI;
          end
          OP_BRANCH: begin
            fmt = FMT_B;
            name = branch_names[f3];
          end
          OP_JALR: begin
            fmt = FMT_I;
            if (f3 == F3_ZERO) begin
              name = NAME_JALR;
              ret = (w[31:20] == 12'h000) && (w[11:7] == ZERO_REG) && (w[19:15] == RA_REG);
            end
          end
          OP_JAL: begin
            fmt = FMT_J;
            name = NAME_JAL;
            jal = 1'b1;
          end
          OP_SYSTEM: begin
            fmt = FMT_I;
            if (w[31:7] == SYS_ECALL_BITS) name = NAME_ECALL;
            else if (w[31:7] == SYS_EBREAK_BITS) name = NAME_EBREAK;
          end
          default: ;
        endcase
      end
      case (fmt)
        FMT_I: imm = {8'h00, w[31:20]};
        FMT_S: imm = {8'h00, w[31:25], w[11:7]};
        FMT_B: imm = {8'h00, w[31], w[7], w[30:25], w[11:8]};
        FMT_U: imm = w[31:12];
        FMT_J: imm = {w[31], w[19:12], w[20], w[30:21]};
        default: imm = '0;
      endcase
      // JAL offset is the byte offset in words: drop bit 0 of the packed field
      d.next_pc = jal ? pc + {{13{imm[19]}}, imm[19:1]} : pc + 32'd1;
      d.stop = ret;
      d.name_code = name;
      d.format = fmt;
      d.packed_imm = imm;
      d.dest_reg = w[11:7];
      d.src1_reg = w[19:15];
      d.src2_reg = w[24:20];
      d.uses_src1 = fmt inside {FMT_R, FMT_I, FMT_S, FMT_B};
      d.uses_src2 = fmt inside {FMT_R, FMT_S, FMT_B};
      d.writes_dest = fmt inside {FMT_R, FMT_I, FMT_B, FMT_U, FMT_J};
      return d;
    endfunction

    function void note_instr(instr_t item);
      if (decode_phase) pending_decodes.push_back(decode_instr(item.instr_word, item.pc_in));
      decode_phase = !decode_phase;
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      $display("tb: %0s got %h want %h", what, got, want);
      errors++;
    endtask

    task check_decoded(decoded_t got);
      decoded_t want;
      if (pending_decodes.size() == 0) begin
        report("beat with nothing pending, next_pc", got.next_pc, '0);
        return;
      end
      want = pending_decodes.pop_front();
      if (got.next_pc !== want.next_pc) report("next_pc", got.next_pc, want.next_pc);
      if (got.stop !== want.stop) report("stop", 32'(got.stop), 32'(want.stop));
      if (got.name_code !== want.name_code)
        report("name_code", 32'(got.name_code), 32'(want.name_code));
      if (got.format !== want.format) report("format", 32'(got.format), 32'(want.format));
      if (got.packed_imm !== want.packed_imm)
        report("packed_imm", 32'(got.packed_imm), 32'(want.packed_imm));
      if (got.dest_reg !== want.dest_reg)
        report("dest_reg", 32'(got.dest_reg), 32'(want.dest_reg));
      if (got.src1_reg !== want.src1_reg)
        report("src1_reg", 32'(got.src1_reg), 32'(want.src1_reg));
      if (got.src2_reg !== want.src2_reg)
        report("src2_reg", 32'(got.src2_reg), 32'(want.src2_reg));
      if (got.uses_src1 !== want.uses_src1)
        report("uses_src1", 32'(got.uses_src1), 32'(want.uses_src1));
      if (got.uses_src2 !== want.uses_src2)
        report("uses_src2", 32'(got.uses_src2), 32'(want.uses_src2));
      if (got.writes_dest !== want.writes_dest)
        report("writes_dest", 32'(got.writes_dest), 32'(want.writes_dest));
    endtask
  endclass

endpackage

// ----- bench/tb.sv -----
// tb: bench top for rv32im_instruction_decoder_top. Drives instruction beats,
// drains decoded beats with random stalls and checks them in order.
// Depends on rvdec_pkg, rvdec_tb_pkg and the decoder RTL.
module tb;
  import rvdec_pkg::*;
  import rvdec_tb_pkg::*;

  logic clk;
  logic rst;
  logic instr_valid;
  logic instr_ready;
  instr_t instr;
  logic dec_valid;
  logic dec_ready;
  decoded_t dec;

  decode_scoreboard sb;
  int unsigned sent;
  int unsigned received;

  rv32im_instruction_decoder_top dut (
    .clk(clk),
    .rst(rst),
    .instr_valid(instr_valid),
    .instr_ready(instr_ready),
    .instr(instr),
    .dec_valid(dec_valid),
    .dec_ready(dec_ready),
    .dec(dec)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #4000000;
    $display("tb: failure");
    $finish;
  end

  task automatic send_instr(logic [31:0] w, logic [31:0] pc);
    int unsigned gap;
    gap = draw_gap((sent / 40) % 4 == 1);
    if (gap != 0) begin
      instr_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    instr_valid <= 1'b1;
    instr <= '{instr_word: w, pc_in: pc};
    do @(posedge clk); while (!instr_ready);
    sb.note_instr(instr);
    sent++;
  endtask

  task automatic hold_until_drained();
    instr_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  initial begin : stimulus
    logic [31:0] w;
    logic [31:0] pc;
    logic [4:0] op;
    logic [6:0] f7;
    int unsigned pick;
    int n;
    sb = new();
    sent = 0;
    rst <= 1'b1;
    instr_valid <= 1'b0;
    instr <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // only every second beat decodes, so each directed word follows a filler
    for (int i = 0; i < 13; i++) begin
      pc = 32'h0000_0100;
      case (i)
        0: begin
          w = '0;
          pc = '0;
        end
        1: begin
          w = '1;
          pc = '1;
        end
        2: w = make_word(F7_ZERO, 5'd0, RA_REG, F3_ZERO, ZERO_REG, OP_JALR);
        3: w = {SYS_ECALL_BITS, OP_SYSTEM, QUAD};
        4: w = {SYS_EBREAK_BITS, OP_SYSTEM, QUAD};
        5: w = make_word(F7_ZERO, 5'd2, 5'd0, F3_ZERO, 5'd0, OP_SYSTEM);
        6: begin
          w = {1'b1, 19'h00000, 5'd0, OP_JAL, QUAD};
          pc = 32'h0000_0010;
        end
        7: begin
          w = {1'b0, 19'h7FFFF, 5'd1, OP_JAL, QUAD};
          pc = 32'hFFFF_FFF0;
        end
        8: w = make_word(F7_MUL, 5'd3, 5'd2, F3_SR, 5'd1, OP_IMM);
        9: w = make_word(F7_ALT, 5'd31, 5'd31, F3_SR, 5'd31, OP_IMM);
        10: w = make_word(F7_ALT, 5'd17, 5'd9, F3_ZERO, 5'd4, OP_REG);
        11: w = make_word(F7_ZERO, 5'd0, 5'd0, F3_ZERO, 5'd0, OP_MISC_MEM);
        // known opcode with bit 1 cleared
        default: w = make_word(F7_ALT, 5'd5, 5'd6, F3_ZERO, 5'd7, OP_IMM) ^ 32'd2;
      endcase
      send_instr(i[0] ? '1 : '0, i[0] ? '0 : '1);
      send_instr(w, pc);
    end

    hold_until_drained();
    repeat (374) begin
      if (sent == 200) hold_until_drained();
      w = $urandom();
      pick = $urandom_range(0, 99);
      if (pick >= 12) begin
        case ($urandom_range(0, 10))
          0: op = OP_LOAD;
          1: op = OP_MISC_MEM;
          2: op = OP_IMM;
          3: op = OP_AUIPC;
          4: op = OP_STORE;
          5: op = OP_REG;
          6: op = OP_LUI;
          7: op = OP_BRANCH;
          8: op = OP_JALR;
          9: op = OP_JAL;
          default: op = OP_SYSTEM;
        endcase
        case ($urandom_range(0, 3))
          0: f7 = F7_ZERO;
          1: f7 = F7_ALT;
          2: f7 = F7_MUL;
          default: f7 = w[31:25];
        endcase
        w = {f7, w[24:7], op, QUAD};
        if (op == OP_SYSTEM && pick < 50)
          w = {pick[0] ? SYS_EBREAK_BITS : SYS_ECALL_BITS, op, QUAD};
        if (op == OP_JALR && pick < 40)
          w = make_word(F7_ZERO, 5'd0, RA_REG, F3_ZERO, ZERO_REG, op);
      end
      case ($urandom_range(0, 9))
        0: pc = '0;
        1: pc = '1;
        default: pc = $urandom();
      endcase
      send_instr(w, pc);
    end

    instr_valid <= 1'b0;
    for (n = 0; n < 5000 && sb.pending() != 0; n++) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.pending() != 0) sb.report("beats never delivered:", sb.pending(), '0);
    if (sb.errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

  initial begin : drain
    int unsigned gap;
    received = 0;
    dec_ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      gap = draw_gap((received / 25) % 3 == 1);
      if (gap != 0) begin
        dec_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      dec_ready <= 1'b1;
      do @(posedge clk); while (!dec_valid);
      sb.check_decoded(dec);
      received++;
    end
  end

endmodule
